// ----- sv/efws_pkg.sv -----
// ----------------------------------------------------------------------------
// efws_pkg
// shared types, constants and helpers for the earliest free worker scheduler
// ----------------------------------------------------------------------------
package efws_pkg;

  localparam int unsigned MAX_WORKERS = 16;
  localparam int unsigned IDX_W       = $clog2(MAX_WORKERS);
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned DUR_W       = 32;
  localparam int unsigned TIME_W      = 48;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } efws_state_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic wr_en;
  } efws_cmd_t;

  typedef struct packed {
    logic last_rd;
    logic out_free;
  } efws_stat_t;

  // highest active worker index: a count of zero acts as one, large counts clip
  function automatic logic [IDX_W-1:0] last_index(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(MAX_WORKERS);
    if (cnt == '0) begin
      last_index = '0;
    end else if (cnt > lim) begin
      last_index = IDX_W'(MAX_WORKERS - 1);
    end else begin
      last_index = IDX_W'(cnt - CNT_W'(1));
    end
  endfunction

  // free time plus duration, clipped at the top of the time range
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                input logic [DUR_W-1:0]  d);
    logic [TIME_W:0] sum;
    sum = {1'b0, t} + {{(TIME_W+1-DUR_W){1'b0}}, d};
    if (sum[TIME_W]) begin
      sat_add = TIME_MAX;
    end else begin
      sat_add = sum[TIME_W-1:0];
    end
  endfunction

endpackage

// ----- sv/efws_ctrl.sv -----
// ----------------------------------------------------------------------------
// efws_ctrl
// job sequencer: accept, scan free times, drain last read, update and emit
// ----------------------------------------------------------------------------
module efws_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  efws_pkg::efws_stat_t  stat,
  output efws_pkg::efws_cmd_t   cmd
);

  efws_pkg::efws_state_t state_r;
  efws_pkg::efws_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= efws_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      efws_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = efws_pkg::ST_SCAN;
      end
      efws_pkg::ST_SCAN: begin
        if (stat.last_rd) state_nxt = efws_pkg::ST_DRAIN;
      end
      efws_pkg::ST_DRAIN: begin
        state_nxt = efws_pkg::ST_UPDATE;
      end
      efws_pkg::ST_UPDATE: begin
        if (stat.out_free) state_nxt = efws_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = efws_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      efws_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      efws_pkg::ST_SCAN: begin
        cmd.rd_en = 1'b1;
      end
      efws_pkg::ST_DRAIN: begin
        cmd = '0;
      end
      efws_pkg::ST_UPDATE: begin
        cmd.wr_en = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // an accepted word always starts a scan
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == efws_pkg::ST_SCAN))
    else $error("accepted word did not start a scan");

endmodule

// ----- sv/efws_dp.sv -----
// ----------------------------------------------------------------------------
// efws_dp
// free time store, running minimum, saturating update and result register
// ----------------------------------------------------------------------------
module efws_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [efws_pkg::CNT_W-1:0]          cfg_wr_data,
  input  logic [efws_pkg::DUR_W-1:0]          in_job_duration,
  input  efws_pkg::efws_cmd_t                 cmd,
  output efws_pkg::efws_stat_t                stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [efws_pkg::IDX_W-1:0]          out_worker_index,
  output logic [efws_pkg::TIME_W-1:0]         out_start_time
);

  logic [efws_pkg::TIME_W-1:0]      mem [efws_pkg::MAX_WORKERS];
  logic [efws_pkg::MAX_WORKERS-1:0] vld_r;

  logic [efws_pkg::CNT_W-1:0]  wc_r;
  logic [efws_pkg::DUR_W-1:0]  dur_r;
  logic [efws_pkg::IDX_W-1:0]  last_r;
  logic [efws_pkg::IDX_W-1:0]  rd_idx_r;
  logic [efws_pkg::IDX_W-1:0]  tag_r;
  logic                        pend_r;
  logic [efws_pkg::TIME_W-1:0] rd_data_r;
  logic                        rd_vld_r;
  logic [efws_pkg::TIME_W-1:0] best_r;
  logic [efws_pkg::IDX_W-1:0]  best_idx_r;
  logic                        out_valid_r;
  logic [efws_pkg::IDX_W-1:0]  out_idx_r;
  logic [efws_pkg::TIME_W-1:0] out_time_r;
  logic [efws_pkg::TIME_W-1:0] cur_time;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r <= efws_pkg::CNT_W'(1);
    end else if (cfg_wr_en) begin
      wc_r <= cfg_wr_data;
    end
  end

  // job word and scan address
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dur_r    <= in_job_duration;
      last_r   <= efws_pkg::last_index(wc_r);
      rd_idx_r <= '0;
    end else if (cmd.rd_en) begin
      rd_idx_r <= rd_idx_r + efws_pkg::IDX_W'(1);
    end
  end

  // free time store, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[best_idx_r] <= efws_pkg::sat_add(best_r, dur_r);
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_idx_r];
      tag_r     <= rd_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      pend_r   <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      pend_r <= cmd.rd_en;
      if (cmd.rd_en) begin
        rd_vld_r <= vld_r[rd_idx_r];
      end
      if (cmd.wr_en) begin
        vld_r[best_idx_r] <= 1'b1;
      end
    end
  end

  assign cur_time = rd_vld_r ? rd_data_r : '0;

  // running minimum, strict less-than keeps the lowest index
  always_ff @(posedge clk) begin
    if (pend_r && ((tag_r == '0) || (cur_time < best_r))) begin
      best_r     <= cur_time;
      best_idx_r <= tag_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.wr_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      out_idx_r  <= best_idx_r;
      out_time_r <= best_r;
    end
  end

  assign stat.last_rd      = (rd_idx_r == last_r);
  assign stat.out_free     = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_worker_index  = out_idx_r;
  assign out_start_time    = out_time_r;

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (rd_idx_r <= last_r))
    else $error("scan address past active workers");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");

  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> (best_idx_r <= last_r))
    else $error("chosen worker not active");

endmodule

// ----- sv/earliest_free_worker_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// earliest_free_worker_scheduler_top
// assigns each job to the worker that becomes free earliest
// ----------------------------------------------------------------------------
// Each accepted job word passes through accept, scan, drain and update before
// the next can be accepted: accept takes the word, scan reads each active
// worker's free time from the single-port free time store and folds it into the
// running minimum, drain lets the last read land, and update writes the updated
// free time and loads the result register. The result register lets a waiting
// result sit while the next job is accepted and scanned; the update then
// holds until out_ready frees the register. Free times are 48 bits, read as zero
// after reset and saturating at the maximum; worker_count 0 acts as 1 and
// counts above 16 act as 16. Change worker_count only while no job is pending.
// ----------------------------------------------------------------------------
module earliest_free_worker_scheduler_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [efws_pkg::CNT_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [efws_pkg::DUR_W-1:0]  in_job_duration,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [efws_pkg::IDX_W-1:0]  out_worker_index,
  output logic [efws_pkg::TIME_W-1:0] out_start_time
);

  efws_pkg::efws_cmd_t  cmd;
  efws_pkg::efws_stat_t stat;

  efws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  efws_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_job_duration  (in_job_duration),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_worker_index (out_worker_index),
    .out_start_time   (out_start_time)
  );

endmodule
